>>> src/assert_macros.svh
// assertion macros shared by the rotation matrix to quaternion block
// expects a clock aclk and an active-low reset aresetn in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define RMQ_ASSERT(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RMQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/rmq_pkg.sv
// shared types and constants for the rotation matrix to quaternion block
// no dependencies
`default_nettype none

package rmq_pkg;

    localparam int unsigned ELEM_W = 16;
    localparam int unsigned LANES  = 3;

    // which component comes straight from the root
    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } rmq_branch_t;

    // control carried alongside the arithmetic cells
    typedef struct packed {
        rmq_branch_t        sel;
        logic               invalid;
        logic [LANES-1:0]   neg;
    } rmq_ctrl_t;

endpackage

`default_nettype wire

>>> src/rmq_sqrt_cell.sv
// one step of the restoring square root: one root bit per cell
// uses no package
`default_nettype none

module rmq_sqrt_cell #(
    parameter int unsigned RW = 16
) (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [2*RW-1:0]   rad_in,
    input  wire logic [RW+1:0]     rem_in,
    input  wire logic [RW-1:0]     root_in,
    output logic      [2*RW-1:0]   rad_reg,
    output logic      [RW+1:0]     rem_reg,
    output logic      [RW-1:0]     root_reg
);

    logic [RW+3:0] rem_next;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    // bring down two radicand bits and try the next root bit
    always_comb begin
        rem_next = {rem_in, rad_in[2*RW-1 -: 2]};
        trial    = {2'b00, root_in, 2'b01};
        diff     = rem_next - trial;
        ge       = (rem_next >= trial);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= {rad_in[2*RW-3:0], 2'b00};
            rem_reg  <= ge ? diff[RW+1:0] : rem_next[RW+1:0];
            root_reg <= {root_in[RW-2:0], ge};
        end
    end

endmodule

`default_nettype wire

>>> src/rmq_div_cell.sv
// one step of the restoring divider: one quotient bit per cell
// uses no package
`default_nettype none

module rmq_div_cell #(
    parameter int unsigned NW = 31,
    parameter int unsigned DW = 17
) (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire logic [NW-1:0]  num_in,
    input  wire logic [DW-1:0]  rem_in,
    input  wire logic [DW-1:0]  div_in,
    input  wire logic [NW-1:0]  quot_in,
    output logic      [NW-1:0]  num_reg,
    output logic      [DW-1:0]  rem_reg,
    output logic      [DW-1:0]  div_reg,
    output logic      [NW-1:0]  quot_reg
);

    logic [DW:0] rem_next;
    logic [DW:0] diff;
    logic        ge;

    // shift in the next numerator bit and subtract if it fits
    always_comb begin
        rem_next = {rem_in, num_in[NW-1]};
        diff     = rem_next - {1'b0, div_in};
        ge       = (rem_next >= {1'b0, div_in});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg  <= {num_in[NW-2:0], 1'b0};
            rem_reg  <= ge ? diff[DW-1:0] : rem_next[DW-1:0];
            div_reg  <= div_in;
            quot_reg <= {quot_in[NW-2:0], ge};
        end
    end

endmodule

`default_nettype wire

>>> src/rotation_matrix_to_quaternion.sv
// top level: rotation matrix to quaternion by the largest-component method
// depends on rmq_pkg, rmq_sqrt_cell, rmq_div_cell and assert_macros.svh
//
// Takes one 3x3 matrix per beat and returns (w, x, y, z) plus an invalid flag in tuser. A new
// matrix is taken every cycle while the skid entry is empty. Each one passes the front register,
// a row of square root cells, one root bit each (RW = root bits), then three rows of divider
// cells, one quotient bit each (NW = FRAC_BITS + 17 quotient bits), before the output register.
// A two-entry output buffer keeps the input open while a result waits.
`default_nettype none

module rotation_matrix_to_quaternion #(
    parameter int unsigned FRAC_BITS = 14
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // m00 m01 m02 m10 m11 m12 m20 m21 m22, 16 bits each
    input  wire logic [143:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // quat_w quat_x quat_y quat_z, 16 bits each
    output logic [63:0]        m_tdata,
    // invalid
    output logic [0:0]         m_tuser
);

    `include "assert_macros.svh"

    localparam int unsigned EW  = rmq_pkg::ELEM_W;
    localparam int unsigned NL  = rmq_pkg::LANES;
    localparam int unsigned AW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int unsigned SW  = AW - 1 + FRAC_BITS;
    localparam int unsigned RW  = (SW + 1) / 2;
    localparam int unsigned DW  = RW + 1;
    localparam int unsigned NW  = FRAC_BITS + 17;
    localparam logic [EW-1:0] ONE_SAT = (FRAC_BITS >= 15) ? 16'h7fff
                                                          : EW'(1 << FRAC_BITS);

    logic en;
    assign en       = s_tready;

    // input fields
    logic signed [EW-1:0] m [0:8];
    always_comb begin
        for (int i = 0; i < 9; i++) m[i] = s_tdata[i*EW +: EW];
    end

    // front stage: branch choice, root argument, lane differences
    logic signed [AW-1:0] e00, e11, e22, trace, arg;
    logic signed [AW-1:0] one_s;
    logic signed [EW:0]   dd [0:NL-1];
    rmq_pkg::rmq_ctrl_t   fr_ctrl;

    always_comb begin
        one_s = AW'(1) <<< FRAC_BITS;
        e00   = AW'(m[0]);
        e11   = AW'(m[4]);
        e22   = AW'(m[8]);
        trace = e00 + e11 + e22;
        if (trace > 0) begin
            fr_ctrl.sel = rmq_pkg::BR_W;
            arg   = one_s + trace;
            dd[0] = (EW+1)'(m[7]) - (EW+1)'(m[5]);
            dd[1] = (EW+1)'(m[2]) - (EW+1)'(m[6]);
            dd[2] = (EW+1)'(m[3]) - (EW+1)'(m[1]);
        end else if (e00 > e11 && e00 > e22) begin
            fr_ctrl.sel = rmq_pkg::BR_X;
            arg   = one_s + e00 - e11 - e22;
            dd[0] = (EW+1)'(m[7]) - (EW+1)'(m[5]);
            dd[1] = (EW+1)'(m[1]) + (EW+1)'(m[3]);
            dd[2] = (EW+1)'(m[2]) + (EW+1)'(m[6]);
        end else if (e11 > e22) begin
            fr_ctrl.sel = rmq_pkg::BR_Y;
            arg   = one_s + e11 - e00 - e22;
            dd[0] = (EW+1)'(m[2]) - (EW+1)'(m[6]);
            dd[1] = (EW+1)'(m[1]) + (EW+1)'(m[3]);
            dd[2] = (EW+1)'(m[5]) + (EW+1)'(m[7]);
        end else begin
            fr_ctrl.sel = rmq_pkg::BR_Z;
            arg   = one_s + e22 - e00 - e11;
            dd[0] = (EW+1)'(m[3]) - (EW+1)'(m[1]);
            dd[1] = (EW+1)'(m[2]) + (EW+1)'(m[6]);
            dd[2] = (EW+1)'(m[5]) + (EW+1)'(m[7]);
        end
        fr_ctrl.invalid = (arg <= 0);
        for (int l = 0; l < NL; l++) fr_ctrl.neg[l] = dd[l][EW];
    end

    // square root row, stage 0 is the front register
    logic                 sq_valid_reg [0:RW];
    rmq_pkg::rmq_ctrl_t   sq_ctrl_reg  [0:RW];
    logic [NW-1:0]        sq_num_reg   [0:RW][0:NL-1];
    logic [2*RW-1:0]      sq_rad       [0:RW];
    logic [RW+1:0]        sq_rem       [0:RW];
    logic [RW-1:0]        sq_root      [0:RW];
    logic [2*RW-1:0]      rad0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (en) begin
            sq_valid_reg[0] <= s_tvalid;
        end
        if (en) begin
            sq_ctrl_reg[0] <= fr_ctrl;
            rad0_reg <= fr_ctrl.invalid ? '0
                      : ((2*RW)'(arg[AW-2:0]) << FRAC_BITS);
            // magnitude kept unsigned so that the most negative sum stays positive
            for (int l = 0; l < NL; l++) begin
                sq_num_reg[0][l] <= (NW'($unsigned(dd[l][EW] ? -dd[l] : dd[l])))
                                    << FRAC_BITS;
            end
        end
    end

    assign sq_rad[0]  = rad0_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        rmq_sqrt_cell #(.RW(RW)) u_cell (
            .aclk     (aclk),
            .en       (en),
            .rad_in   (sq_rad[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .rad_reg  (sq_rad[k+1]),
            .rem_reg  (sq_rem[k+1]),
            .root_reg (sq_root[k+1])
        );

        // side info travels with the root
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
            if (en) begin
                sq_ctrl_reg[k+1] <= sq_ctrl_reg[k];
                sq_num_reg[k+1]  <= sq_num_reg[k];
            end
        end
    end

    // divider rows, three lanes side by side
    logic                 dv_valid_reg [1:NW];
    rmq_pkg::rmq_ctrl_t   dv_ctrl_reg  [1:NW];
    logic [RW-1:0]        dv_root_reg  [1:NW];
    logic [NW-1:0]        dv_num       [0:NW][0:NL-1];
    logic [DW-1:0]        dv_rem       [0:NW][0:NL-1];
    logic [DW-1:0]        dv_div       [0:NW][0:NL-1];
    logic [NW-1:0]        dv_quot      [0:NW][0:NL-1];

    for (genvar l = 0; l < NL; l++) begin : g_lane0
        assign dv_num[0][l]  = sq_num_reg[RW][l];
        assign dv_rem[0][l]  = '0;
        assign dv_div[0][l]  = {sq_root[RW], 1'b0};
        assign dv_quot[0][l] = '0;
    end

    for (genvar j = 0; j < NW; j++) begin : g_div
        logic               v_prev;
        rmq_pkg::rmq_ctrl_t c_prev;
        logic [RW-1:0]      r_prev;

        // first divider stage takes its side info from the root row
        if (j == 0) begin : g_first
            assign v_prev = sq_valid_reg[RW];
            assign c_prev = sq_ctrl_reg[RW];
            assign r_prev = sq_root[RW];
        end else begin : g_next
            assign v_prev = dv_valid_reg[j];
            assign c_prev = dv_ctrl_reg[j];
            assign r_prev = dv_root_reg[j];
        end

        for (genvar l = 0; l < NL; l++) begin : g_lane
            rmq_div_cell #(.NW(NW), .DW(DW)) u_cell (
                .aclk     (aclk),
                .en       (en),
                .num_in   (dv_num[j][l]),
                .rem_in   (dv_rem[j][l]),
                .div_in   (dv_div[j][l]),
                .quot_in  (dv_quot[j][l]),
                .num_reg  (dv_num[j+1][l]),
                .rem_reg  (dv_rem[j+1][l]),
                .div_reg  (dv_div[j+1][l]),
                .quot_reg (dv_quot[j+1][l])
            );
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[j+1] <= v_prev;
            end
            if (en) begin
                dv_ctrl_reg[j+1] <= c_prev;
                dv_root_reg[j+1] <= r_prev;
            end
        end
    end

    // saturate and place the components
    logic [EW-1:0]      lane_s [0:NL-1];
    logic [EW-1:0]      half_s;
    logic [RW-1:0]      half;
    logic [NW-1:0]      qmag;
    logic [4*EW-1:0]    res_data;
    rmq_pkg::rmq_ctrl_t rc;

    always_comb begin
        rc   = dv_ctrl_reg[NW];
        half = dv_root_reg[NW] >> 1;
        half_s = (NW'(half) > NW'(16'h7fff)) ? 16'h7fff : EW'(half);
        for (int l = 0; l < NL; l++) begin
            qmag = dv_quot[NW][l];
            if (rc.neg[l]) begin
                lane_s[l] = (qmag > NW'(17'h08000)) ? 16'h8000 : EW'(-qmag);
            end else begin
                lane_s[l] = (qmag > NW'(16'h7fff)) ? 16'h7fff : EW'(qmag);
            end
        end
        unique case (rc.sel)
            rmq_pkg::BR_W: res_data = {lane_s[2], lane_s[1], lane_s[0], half_s};
            rmq_pkg::BR_X: res_data = {lane_s[2], lane_s[1], half_s, lane_s[0]};
            rmq_pkg::BR_Y: res_data = {lane_s[2], half_s, lane_s[1], lane_s[0]};
            rmq_pkg::BR_Z: res_data = {half_s, lane_s[2], lane_s[1], lane_s[0]};
            default:       res_data = '0;
        endcase
        if (rc.invalid) res_data = {48'h0, ONE_SAT};
    end

    // output register with one skid entry
    logic            out_valid_reg, skid_valid_reg;
    logic [4*EW-1:0] out_data_reg, skid_data_reg;
    logic            out_inv_reg, skid_inv_reg;
    logic            last_valid;

    assign last_valid = dv_valid_reg[NW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            if (out_valid_reg && !m_tready) begin
                if (last_valid) begin
                    skid_valid_reg <= 1'b1;
                    skid_data_reg  <= res_data;
                    skid_inv_reg   <= rc.invalid;
                end
            end else begin
                out_valid_reg <= last_valid;
                out_data_reg  <= res_data;
                out_inv_reg   <= rc.invalid;
            end
        end else if (m_tready) begin
            out_data_reg   <= skid_data_reg;
            out_inv_reg    <= skid_inv_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_inv_reg;

    // checks
    `RMQ_ASSERT(a_skid_has_out, !skid_valid_reg || out_valid_reg, "skid full with output empty")
    `RMQ_ASSERT_IMP(a_skid_only_on_stall, $rose(skid_valid_reg), !$past(m_tready), "skid filled without stall")
    `RMQ_ASSERT_IMP(a_invalid_identity, m_tvalid && m_tuser[0], m_tdata[63:16] == 48'h0, "invalid result is not identity")

endmodule

`default_nettype wire

>>> tb/tb_rotation_matrix_to_quaternion.sv
// testbench for rotation_matrix_to_quaternion: random and directed matrices, self-checking
// depends on rmq_pkg and the rotation_matrix_to_quaternion rtl
`default_nettype none

module tb_rotation_matrix_to_quaternion;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 14;
    localparam longint ONE = 64'sd1 <<< FRAC;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               invalid;
    } quat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    logic [143:0] matrix_q[$];
    quat_t        quat_q[$];
    int           errors = 0;
    int           send_idle = 0;
    int           recv_stall = 0;
    bit           hold_send = 0;
    bit           in_taken = 1'b0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    // integer square root, floor
    function automatic longint isqrt(longint a);
        longint res, bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > a) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (a >= res + bitv) begin
                a = a - (res + bitv);
                res = (res >>> 1) + bitv;
            end else begin
                res = res >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // largest-component conversion of one matrix beat
    function automatic quat_t to_quat(logic [143:0] d);
        longint m[9];
        longint tr, arg, root, half, tw, q[4];
        rmq_pkg::rmq_branch_t br;
        quat_t r;
        for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
        tr = m[0] + m[4] + m[8];
        if (tr > 0) begin
            br = rmq_pkg::BR_W; arg = ONE + tr;
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            br = rmq_pkg::BR_X; arg = ONE + m[0] - m[4] - m[8];
        end else if (m[4] > m[8]) begin
            br = rmq_pkg::BR_Y; arg = ONE + m[4] - m[0] - m[8];
        end else begin
            br = rmq_pkg::BR_Z; arg = ONE + m[8] - m[0] - m[4];
        end
        if (arg <= 0) begin
            r.w = clamp16(ONE); r.x = 0; r.y = 0; r.z = 0; r.invalid = 1'b1;
            return r;
        end
        root = isqrt(arg <<< FRAC);
        half = root >>> 1;
        tw = root * 2;
        case (br)
            rmq_pkg::BR_W: begin
                q[0] = half;
                q[1] = ((m[7] - m[5]) * ONE) / tw;
                q[2] = ((m[2] - m[6]) * ONE) / tw;
                q[3] = ((m[3] - m[1]) * ONE) / tw;
            end
            rmq_pkg::BR_X: begin
                q[0] = ((m[7] - m[5]) * ONE) / tw;
                q[1] = half;
                q[2] = ((m[1] + m[3]) * ONE) / tw;
                q[3] = ((m[2] + m[6]) * ONE) / tw;
            end
            rmq_pkg::BR_Y: begin
                q[0] = ((m[2] - m[6]) * ONE) / tw;
                q[1] = ((m[1] + m[3]) * ONE) / tw;
                q[2] = half;
                q[3] = ((m[5] + m[7]) * ONE) / tw;
            end
            default: begin
                q[0] = ((m[3] - m[1]) * ONE) / tw;
                q[1] = ((m[2] + m[6]) * ONE) / tw;
                q[2] = ((m[5] + m[7]) * ONE) / tw;
                q[3] = half;
            end
        endcase
        r.w = clamp16(q[0]); r.x = clamp16(q[1]);
        r.y = clamp16(q[2]); r.z = clamp16(q[3]);
        r.invalid = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [15:0] pick(int mode);
        case (mode)
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'h7fff;
            3: return 16'h8000;
            4: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // random matrix: elements in [-16384, 16384], full-range random, or picked from edge values and random
    function automatic logic [143:0] rand_matrix();
        logic [143:0] d;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) begin
            if (kind < 6)
                d[16*i +: 16] = 16'($signed($urandom_range(0, 32768)) - 16384);
            else if (kind < 8)
                d[16*i +: 16] = 16'($urandom);
            else
                d[16*i +: 16] = pick($urandom_range(0, 5));
        end
        return d;
    endfunction

    // driver: falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            // load a new beat once the current one was taken at the last rising edge
            if (!s_tvalid || in_taken) begin
                if (matrix_q.size() != 0 && !hold_send &&
                    !(send_idle > 0 && $urandom_range(0, 99) < send_idle)) begin
                    s_tdata  <= matrix_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
        end
    end

    // monitor: rising edge
    always @(posedge aclk) begin
        quat_t got, want;
        // input beat accepted at this edge
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) quat_q.push_back(to_quat(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48], m_tuser[0]};
            if (quat_q.size() == 0) begin
                report_mismatch("unexpected beat", 0, 0);
            end else begin
                want = quat_q.pop_front();
                if (got.w != want.w) report_mismatch("quat_w", got.w, want.w);
                if (got.x != want.x) report_mismatch("quat_x", got.x, want.x);
                if (got.y != want.y) report_mismatch("quat_y", got.y, want.y);
                if (got.z != want.z) report_mismatch("quat_z", got.z, want.z);
                if (got.invalid != want.invalid)
                    report_mismatch("invalid", got.invalid, want.invalid);
            end
        end
    end

    task automatic drain();
        while (matrix_q.size() != 0 || s_tvalid || quat_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [143:0] diag(int a, int b, int c);
        logic [143:0] d;
        d = '0;
        d[15:0] = 16'(a); d[79:64] = 16'(b); d[143:128] = 16'(c);
        return d;
    endfunction

    initial begin
        logic [143:0] d;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: identity, half-turns, ties, extremes
        matrix_q.push_back(diag(16384, 16384, 16384));
        matrix_q.push_back(diag(16384, -16384, -16384));
        matrix_q.push_back(diag(-16384, 16384, -16384));
        matrix_q.push_back(diag(-16384, -16384, 16384));
        matrix_q.push_back(diag(0, 0, 0));
        matrix_q.push_back(diag(-16384, -16384, -16384));
        matrix_q.push_back(diag(-32768, -32768, -32768));
        matrix_q.push_back(diag(32767, 32767, 32767));
        matrix_q.push_back(diag(-10000, -10000, -10000));
        matrix_q.push_back(diag(5000, -3000, -8000));
        matrix_q.push_back({9{16'h7fff}});
        matrix_q.push_back({9{16'h8000}});
        matrix_q.push_back({9{16'hffff}});
        d = diag(1, 1, -2);
        d[31:16] = 16'h7fff; d[47:32] = 16'h8000; d[63:48] = 16'h7fff;
        d[95:80] = 16'h8000; d[111:96] = 16'h7fff; d[127:112] = 16'h8000;
        matrix_q.push_back(d);
        d = diag(0, 0, 0);
        d[31:16] = 16'(16384); d[63:48] = 16'(-16384);
        matrix_q.push_back(d);
        d = diag(-1, 8000, 8000);
        d[95:80] = 16'h7fff; d[127:112] = 16'h7fff;
        matrix_q.push_back(d);
        drain();

        // phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1) ? 52 : (ph == 3) ? 22 : 0;
            recv_stall = (ph == 2) ? 52 : (ph == 3) ? 22 : 0;
            for (int i = 0; i < 435; i++) begin
                matrix_q.push_back(rand_matrix());
                if (i == 200) begin
                    // pause until all results are back
                    while (matrix_q.size() != 0 || s_tvalid) @(posedge aclk);
                    hold_send = 1;
                    while (quat_q.size() != 0) @(posedge aclk);
                    hold_send = 0;
                end
            end
            drain();
        end
        repeat (60) @(posedge aclk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end
endmodule

`default_nettype wire
